// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

	// Default screen geometry.
	localparam int COLUMNS_DEF = 80;
	localparam int LINES_DEF   = 25;

	// Character codes and reset values.
	localparam logic [7:0]  BYTE_LF    = 8'h0A;
	localparam logic [7:0]  BYTE_BS    = 8'h08;
	localparam logic [7:0]  BYTE_CR    = 8'h0D;
	localparam logic [7:0]  BYTE_SPACE = 8'h20;
	localparam logic [7:0]  ATTR_RESET = 8'h07;
	localparam logic [15:0] CELL_RESET = 16'h0720;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_SET   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} tcw_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESP
	} tcw_state_t;

	typedef struct packed {
		tcw_op_t    op;
		logic [7:0] char_code;
		logic [7:0] col;
		logic [7:0] row;
	} tcw_cmd_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_pos;
		logic        error;
		logic        scrolled;
	} tcw_rsp_t;

endpackage

// ----- rtl/core/tcw_cell_ram.sv -----
// Screen cell store: one write port and one read port with registered read data.
module tcw_cell_ram #(
	parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::LINES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/text_console_cell_writer.sv -----
// Set cursor, read cell and a put character that does not scroll give their result
// strobe in the cycle after the accepting edge.
// A scroll or a screen clear sweeps the whole cell store, bound by the single write
// port of the store. Throughput is one transaction per completion; results cannot be
// stalled. After reset the block sweeps the store to blank cells.
module text_console_cell_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int LINES   = tcw_pkg::LINES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcw_pkg::tcw_cmd_t cmd,
	output logic             done,
	output tcw_pkg::tcw_rsp_t rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	// Geometry derived from the parameters. The store is linear, row-major.
	localparam int CELLS    = COLUMNS * LINES;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ROW_W    = $clog2(LINES);
	localparam int COPY_END = CELLS - COLUMNS;

	tcw_pkg::tcw_state_t state_q, state_nx;

	// Cursor kept both as (col, row) and as a linear cell position.
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;
	logic [7:0]        attr_q;

	// Sweep engine: one address counter walks the store for clear, scroll and the
	// power-up fill. A scroll reads the cell one line below and writes it in the next
	// cycle; addresses in the last line are written with the fill value instead.
	logic [ADDR_W-1:0] idx_q;
	logic              scroll_q;
	logic              init_q;
	logic [15:0]       fill_q;
	logic              v_s1;
	logic              cp_s1;
	logic [ADDR_W-1:0] dst_s1;

	// Result side registers.
	logic err_q;
	logic scrolled_q;
	logic rd_ok_q;

	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] cmd_addr;
	logic              cp_now;

	// Put character decode.
	logic              put_we;
	logic [ADDR_W-1:0] put_addr;
	logic [15:0]       put_data;
	logic [COL_W-1:0]  put_col;
	logic [ROW_W-1:0]  put_row;
	logic [ADDR_W-1:0] put_pos;
	logic              put_scroll;

	// Store ports.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	// The attribute register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	assign accept   = start & ~busy;
	assign in_range = (cmd.col < 8'(COLUMNS)) && (cmd.row < 8'(LINES));
	assign cmd_addr = ADDR_W'(cmd.row[ROW_W-1:0]) * ADDR_W'(COLUMNS)
		+ ADDR_W'(cmd.col[COL_W-1:0]);
	assign cp_now   = scroll_q && (idx_q < ADDR_W'(COPY_END));

	// Put character: work out the cell write and the new cursor from the current one.
	always_comb begin
		logic [7:0]        c;
		logic [ADDR_W-1:0] line_start;
		logic              col_last;
		logic              row_last;
		logic              newline;
		logic              advance;

		c          = cmd.char_code;
		line_start = pos_q - ADDR_W'(col_q);
		col_last   = (col_q == COL_W'(COLUMNS - 1));
		row_last   = (row_q == ROW_W'(LINES - 1));
		newline    = 1'b0;
		advance    = 1'b0;

		put_we     = 1'b0;
		put_addr   = pos_q;
		put_data   = {attr_q, c};
		put_col    = col_q;
		put_row    = row_q;
		put_pos    = pos_q;
		put_scroll = 1'b0;

		if (!c[7] && (c[6:5] != 2'b00)) begin
			// Printable byte.
			put_we  = 1'b1;
			advance = 1'b1;
		end else if (c == tcw_pkg::BYTE_LF) begin
			newline = 1'b1;
		end else if (c == tcw_pkg::BYTE_CR) begin
			put_col = '0;
			put_pos = line_start;
		end else if (c == tcw_pkg::BYTE_BS) begin
			if (col_q != '0) begin
				put_col = col_q - 1'b1;
				put_pos = pos_q - 1'b1;
			end
			put_we   = 1'b1;
			put_addr = put_pos;
			put_data = {attr_q, tcw_pkg::BYTE_SPACE};
		end else begin
			// Control or high byte: shown with foreground and background swapped.
			put_we   = 1'b1;
			put_data = {attr_q[3:0], attr_q[7:4], c};
			advance  = 1'b1;
		end

		if (advance) begin
			if (col_last) begin
				newline = 1'b1;
			end else begin
				put_col = col_q + 1'b1;
				put_pos = pos_q + 1'b1;
			end
		end

		if (newline) begin
			put_col = '0;
			if (row_last) begin
				// Cursor stays on the last line, which the scroll blanks.
				put_scroll = 1'b1;
				put_pos    = line_start;
			end else begin
				put_row = row_q + 1'b1;
				put_pos = line_start + ADDR_W'(COLUMNS);
			end
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						tcw_pkg::OP_PUT:   state_nx = put_scroll ? tcw_pkg::ST_SWEEP
							: tcw_pkg::ST_RESP;
						tcw_pkg::OP_CLEAR: state_nx = tcw_pkg::ST_SWEEP;
						default:           state_nx = tcw_pkg::ST_RESP;
					endcase
				end
			end
			tcw_pkg::ST_SWEEP: begin
				if (idx_q == ADDR_W'(CELLS - 1)) begin
					state_nx = tcw_pkg::ST_DRAIN;
				end
			end
			tcw_pkg::ST_DRAIN: begin
				state_nx = init_q ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_RESP: begin
				state_nx = tcw_pkg::ST_IDLE;
			end
			default: begin
				state_nx = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and store port control.
	always_comb begin
		busy      = (state_q != tcw_pkg::ST_IDLE);
		done      = (state_q == tcw_pkg::ST_RESP);
		ram_re    = 1'b0;
		ram_raddr = cmd_addr;
		unique case (state_q)
			tcw_pkg::ST_IDLE: begin
				ram_re = accept && (cmd.op == tcw_pkg::OP_READ) && in_range;
			end
			tcw_pkg::ST_SWEEP: begin
				ram_re    = cp_now;
				ram_raddr = idx_q + ADDR_W'(COLUMNS);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase

		// The sweep write stage has the port whenever it holds a cell; a put
		// character is only taken in idle, when that stage is empty.
		if (v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = dst_s1;
			ram_wdata = cp_s1 ? ram_rdata : fill_q;
		end else begin
			ram_we    = accept && (cmd.op == tcw_pkg::OP_PUT) && put_we;
			ram_waddr = put_addr;
			ram_wdata = put_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::ST_SWEEP;
			col_q      <= '0;
			row_q      <= '0;
			pos_q      <= '0;
			attr_q     <= tcw_pkg::ATTR_RESET;
			idx_q      <= '0;
			scroll_q   <= 1'b0;
			init_q     <= 1'b1;
			fill_q     <= tcw_pkg::CELL_RESET;
			v_s1       <= 1'b0;
			cp_s1      <= 1'b0;
			dst_s1     <= '0;
			err_q      <= 1'b0;
			scrolled_q <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end

			v_s1   <= (state_q == tcw_pkg::ST_SWEEP);
			cp_s1  <= cp_now;
			dst_s1 <= idx_q;
			if (state_q == tcw_pkg::ST_SWEEP) begin
				idx_q <= idx_q + 1'b1;
			end

			if (accept) begin
				idx_q      <= '0;
				init_q     <= 1'b0;
				fill_q     <= {attr_q, tcw_pkg::BYTE_SPACE};
				scroll_q   <= (cmd.op == tcw_pkg::OP_PUT) && put_scroll;
				scrolled_q <= (cmd.op == tcw_pkg::OP_PUT) && put_scroll;
				err_q      <= ((cmd.op == tcw_pkg::OP_SET) || (cmd.op == tcw_pkg::OP_READ))
					&& !in_range;
				rd_ok_q    <= (cmd.op == tcw_pkg::OP_READ) && in_range;
				unique case (cmd.op)
					tcw_pkg::OP_PUT: begin
						col_q <= put_col;
						row_q <= put_row;
						pos_q <= put_pos;
					end
					tcw_pkg::OP_SET: begin
						if (in_range) begin
							col_q <= cmd.col[COL_W-1:0];
							row_q <= cmd.row[ROW_W-1:0];
							pos_q <= cmd_addr;
						end
					end
					tcw_pkg::OP_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
						pos_q <= '0;
					end
					default: begin
						col_q <= col_q;
					end
				endcase
			end
		end
	end

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The read data register is left alone after a read, so it still holds the
	// cell while the result is shown.
	assign rsp.cell_data  = rd_ok_q ? ram_rdata : 16'h0000;
	assign rsp.cursor_col = 7'(col_q);
	assign rsp.cursor_row = 5'(row_q);
	assign rsp.cursor_pos = 11'(pos_q);
	assign rsp.error      = err_q;
	assign rsp.scrolled   = scrolled_q;

`ifndef SYNTH
	// The linear position always tracks the cursor coordinates.
	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q))
		else $error("cursor position out of step with column and row");

	// The cursor never leaves the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < LINES))
		else $error("cursor outside the screen");

	// The sweep write stage only holds a cell while sweeping or draining.
	a_s1_phase: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == tcw_pkg::ST_SWEEP || state_q == tcw_pkg::ST_DRAIN))
		else $error("sweep write outside the sweep");

	// A scroll always leaves the cursor on the last line.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.scrolled) |-> (row_q == ROW_W'(LINES - 1)))
		else $error("scrolled result with cursor off the last line");
`endif

endmodule
